/* rtl/core/mhsgd_pkg.sv */
package mhsgd_pkg;

   localparam int unsigned HEADS = 4;

   typedef enum logic [1:0] {
      ACT_WRITE  = 2'd0,
      ACT_READ   = 2'd1,
      ACT_SAMPLE = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [0:0] {
      KIND_READ   = 1'b0,
      KIND_UPDATE = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_ACC_RD,
      ST_ACC_MUL,
      ST_ACC_ADD,
      ST_ERR,
      ST_UPD_RD,
      ST_UPD_G1,
      ST_UPD_G2,
      ST_UPD_W1,
      ST_UPD_W2,
      ST_BIAS1,
      ST_BIAS2,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [6:0]         weight_slot;
      logic signed [31:0] write_value;
      logic signed [31:0] feature_value;
      logic               last_feature;
      logic signed [31:0] target_h1;
      logic signed [31:0] target_h5;
      logic signed [31:0] target_h10;
      logic signed [31:0] target_h20;
      logic [3:0]         horizon_mask;
      logic [16:0]        step_rate;
   } req_type;

   typedef struct packed {
      logic               report_kind;
      logic signed [31:0] read_value;
      logic signed [31:0] error_h1;
      logic signed [31:0] error_h5;
      logic signed [31:0] error_h10;
      logic signed [31:0] error_h20;
      logic [3:0]         applied_mask;
   } rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return -32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
      if (v < -64'sh8000_0000_0000) return -48'sh8000_0000_0000;
      return v[47:0];
   endfunction

endpackage

/* rtl/core/multi_head_sgd_regression_update_unit.sv */
// Four-head linear regression trainer with L2-regularized SGD, Q16.16.
// Input channel req_*: one transaction is a weight write, a weight read or
// one feature sample (req_valid / req_stall, accepted when valid and not
// stalled). Result channel rsp_*: read data or one update report per vector.
// Configuration csr_*: one register, l2_gain, written on valid and ready;
// write only while the block is idle.
// Weights and biases live in one single-port memory with a registered read.
// A write goes into the memory in the cycle it is accepted; a read passes
// through ST_READ and ST_DONE to the result register. A feature sample is
// worked head by head (read weight, multiply, accumulate through one shared
// product register). A last feature adds the update walk: per enabled head
// ST_ERR, per weight UPD_RD, G1, G2, W1, W2, then BIAS1 and BIAS2; a skipped
// head passes only ST_ERR; ST_DONE then loads the result register.
// The sequencer handles one transaction at a time; req_stall is high while
// busy or while a result waits in the output register.
// Reset clears l2_gain, the feature count and accumulators, and sweeps the
// memory to zero, during which no transaction is taken.
// When rsp_stall is high the result holds in the output register.
module multi_head_sgd_regression_update_unit
   import mhsgd_pkg::*;
#(
   parameter int unsigned FEATURES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_data
);

   localparam int unsigned NW    = HEADS * FEATURES;
   localparam int unsigned DEPTH = NW + HEADS;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned FW    = $clog2(FEATURES + 1);
   localparam int unsigned IW    = (FEATURES > 1) ? $clog2(FEATURES) : 1;

   // memory and feature buffer
   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] fbuf [FEATURES];
   logic signed [31:0] rd_ff;
   logic [AW-1:0]      addr;
   logic               we;
   logic signed [31:0] wdata;

   state_type          st_ff, st_in;
   req_type            req_ff;
   logic [16:0]        l2_ff;
   logic [FW-1:0]      cnt_ff;
   logic signed [47:0] acc_ff [HEADS];
   logic [1:0]         h_ff, h_in;
   logic [IW:0]        i_ff, i_in;
   logic signed [31:0] err_ff [HEADS];
   logic signed [31:0] cur_err_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] w_ff;
   logic signed [63:0] g_ff;
   logic               clr_ff;
   logic [AW:0]        clr_cnt_ff;
   logic               ovalid_ff;
   rsp_type            orsp_ff;

   logic signed [31:0] feat;
   logic signed [31:0] tgt;
   logic               slot_ok;

   assign csr_ready = 1'b1;
   assign rsp_valid = ovalid_ff;
   assign rsp_data  = orsp_ff;
   assign req_stall = clr_ff || (st_ff != ST_IDLE) || ovalid_ff;

   assign slot_ok = {1'b0, req_ff.weight_slot} < 8'(DEPTH);
   assign feat    = ({1'b0, i_ff} < {1'b0, cnt_ff}) ? fbuf[i_ff[IW-1:0]] : 32'sd0;

   always_comb begin
      unique case (h_ff)
         2'd0:    tgt = req_ff.target_h1;
         2'd1:    tgt = req_ff.target_h5;
         2'd2:    tgt = req_ff.target_h10;
         default: tgt = req_ff.target_h20;
      endcase
   end

   // memory port: address and write select per state
   always_comb begin
      addr  = '0;
      we    = 1'b0;
      wdata = 32'sd0;
      if (clr_ff) begin
         addr = clr_cnt_ff[AW-1:0];
         we   = 1'b1;
      end else begin
         unique case (st_ff)
            ST_IDLE: begin
               addr  = AW'(req_data.weight_slot);
               we    = req_valid && !req_stall && req_data.action == ACT_WRITE &&
                       {1'b0, req_data.weight_slot} < 8'(DEPTH);
               wdata = req_data.write_value;
            end
            ST_READ: addr = AW'(req_ff.weight_slot);
            ST_ACC_RD, ST_UPD_RD, ST_UPD_G1, ST_UPD_G2, ST_UPD_W1:
               addr = AW'(h_ff * FEATURES + i_ff[IW-1:0]);
            ST_UPD_W2: begin
               addr  = AW'(h_ff * FEATURES + i_ff[IW-1:0]);
               we    = 1'b1;
               wdata = sat32(64'(w_ff) - (prod_ff >>> 16));
            end
            ST_ERR, ST_BIAS1: addr = AW'(NW + h_ff);
            ST_BIAS2: begin
               addr  = AW'(NW + h_ff);
               we    = 1'b1;
               wdata = sat32(64'(rd_ff) - (prod_ff >>> 16));
            end
            default: addr = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rd_ff <= mem[addr];
   end

   // next state
   always_comb begin
      st_in = st_ff;
      h_in  = h_ff;
      i_in  = i_ff;
      unique case (st_ff)
         ST_IDLE:
            if (req_valid && !req_stall) begin
               priority if (req_data.action == ACT_READ) st_in = ST_READ;
               else if (req_data.action == ACT_SAMPLE) begin
                  h_in = 2'd0;
                  i_in = (IW+1)'(cnt_ff);
                  st_in = ({1'b0, cnt_ff} < (FW+1)'(FEATURES)) ? ST_ACC_RD :
                          (req_data.last_feature ? ST_ERR : ST_IDLE);
               end
               else st_in = ST_IDLE;
            end
         ST_READ:    st_in = ST_DONE;
         ST_ACC_RD:  st_in = ST_ACC_MUL;
         ST_ACC_MUL: st_in = ST_ACC_ADD;
         ST_ACC_ADD: begin
            h_in = h_ff + 2'd1;
            if (h_ff == 2'd3) begin
               h_in  = 2'd0;
               st_in = req_ff.last_feature ? ST_ERR : ST_IDLE;
            end else st_in = ST_ACC_RD;
         end
         ST_ERR: begin
            i_in = '0;
            st_in = req_ff.horizon_mask[h_ff] ? ST_UPD_RD :
                    (h_ff == 2'd3 ? ST_DONE : ST_ERR);
            if (!req_ff.horizon_mask[h_ff]) h_in = h_ff + 2'd1;
         end
         ST_UPD_RD: st_in = ST_UPD_G1;
         ST_UPD_G1: st_in = ST_UPD_G2;
         ST_UPD_G2: st_in = ST_UPD_W1;
         ST_UPD_W1: st_in = ST_UPD_W2;
         ST_UPD_W2: begin
            i_in  = i_ff + 1'b1;
            st_in = (i_ff == (IW+1)'(FEATURES - 1)) ? ST_BIAS1 : ST_UPD_RD;
         end
         ST_BIAS1: st_in = ST_BIAS2;
         ST_BIAS2: begin
            h_in  = h_ff + 2'd1;
            st_in = (h_ff == 2'd3) ? ST_DONE : ST_ERR;
         end
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         h_ff  <= '0;
         i_ff  <= '0;
      end else begin
         st_ff <= st_in;
         h_ff  <= h_in;
         i_ff  <= i_in;
      end
   end

   // clear sweep, config, counters, accumulators and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
         l2_ff      <= '0;
         cnt_ff     <= '0;
         ovalid_ff  <= 1'b0;
         for (int k = 0; k < HEADS; k++) acc_ff[k] <= '0;
      end else begin
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == (AW+1)'(DEPTH - 1)) clr_ff <= 1'b0;
         end
         if (csr_valid) l2_ff <= csr_data;
         if (ovalid_ff && !rsp_stall) ovalid_ff <= 1'b0;
         if (st_ff == ST_IDLE && req_valid && !req_stall) req_ff <= req_data;
         unique case (st_ff)
            ST_IDLE: if (req_valid && !req_stall && req_data.action == ACT_SAMPLE &&
                         {1'b0, cnt_ff} < (FW+1)'(FEATURES))
               fbuf[cnt_ff[IW-1:0]] <= req_data.feature_value;
            ST_ACC_MUL: prod_ff <= 64'(rd_ff) * 64'(req_ff.feature_value);
            ST_ACC_ADD: begin
               acc_ff[h_ff] <= sat48(64'(acc_ff[h_ff]) + (prod_ff >>> 16));
               if (h_ff == 2'd3) cnt_ff <= cnt_ff + 1'b1;
            end
            ST_READ: ;
            ST_ERR: begin
               err_ff[h_ff] <= 32'sd0;
            end
            ST_UPD_RD: begin
               if (i_ff == '0) begin
                  cur_err_ff   <= sat32(64'(acc_ff[h_ff]) + 64'(rd_ff) - 64'(tgt));
                  err_ff[h_ff] <= sat32(64'(acc_ff[h_ff]) + 64'(rd_ff) - 64'(tgt));
               end
            end
            ST_UPD_G1: begin
               w_ff    <= rd_ff;
               prod_ff <= 64'(cur_err_ff) * 64'(feat);
            end
            ST_UPD_G2: begin
               g_ff    <= prod_ff >>> 16;
               prod_ff <= 64'($signed({1'b0, l2_ff})) * 64'(w_ff);
            end
            ST_UPD_W1:
               prod_ff <= 64'($signed({1'b0, req_ff.step_rate})) *
                          64'(sat32(g_ff + (prod_ff >>> 16)));
            ST_BIAS1: begin
               prod_ff <= 64'($signed({1'b0, req_ff.step_rate})) * 64'(cur_err_ff);
            end
            ST_DONE: begin
               ovalid_ff <= 1'b1;
               if (req_ff.action == ACT_READ) begin
                  orsp_ff.report_kind  <= KIND_READ;
                  orsp_ff.read_value   <= slot_ok ? rd_ff : 32'sd0;
                  orsp_ff.error_h1     <= '0;
                  orsp_ff.error_h5     <= '0;
                  orsp_ff.error_h10    <= '0;
                  orsp_ff.error_h20    <= '0;
                  orsp_ff.applied_mask <= '0;
               end else begin
                  orsp_ff.report_kind  <= KIND_UPDATE;
                  orsp_ff.read_value   <= '0;
                  orsp_ff.error_h1     <= req_ff.horizon_mask[0] ? err_ff[0] : 32'sd0;
                  orsp_ff.error_h5     <= req_ff.horizon_mask[1] ? err_ff[1] : 32'sd0;
                  orsp_ff.error_h10    <= req_ff.horizon_mask[2] ? err_ff[2] : 32'sd0;
                  orsp_ff.error_h20    <= req_ff.horizon_mask[3] ? err_ff[3] : 32'sd0;
                  orsp_ff.applied_mask <= req_ff.horizon_mask;
                  cnt_ff <= '0;
                  for (int k = 0; k < HEADS; k++) acc_ff[k] <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // result register only loads when empty
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ovalid_ff && rsp_stall |=> ovalid_ff && $stable(orsp_ff))
      else $error("result overwritten while stalled");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      st_ff != ST_IDLE |-> req_stall)
      else $error("input taken while busy");
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> st_ff == ST_IDLE && !ovalid_ff)
      else $error("activity during clear sweep");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cnt_ff} <= (FW+1)'(FEATURES))
      else $error("feature count overflow");

endmodule

/* tb/sv/multi_head_sgd_regression_update_unit_test.sv */
`timescale 1ns / 100ps

module multi_head_sgd_regression_update_unit_test;
   import mhsgd_pkg::*;

   localparam int unsigned FEATURES = 16;
   localparam int unsigned NSLOTS = 4 * FEATURES;
   localparam int unsigned CYCLE_LIMIT = 4000000;
   localparam int unsigned DRAIN_CYCLES = 400;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [16:0] csr_data;

   multi_head_sgd_regression_update_unit #(.FEATURES(FEATURES)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // shadow state of the trainer
   logic [16:0]        l2_shadow;
   logic signed [31:0] weight_shadow [NSLOTS];
   logic signed [31:0] bias_shadow [HEADS];
   logic signed [31:0] feature_shadow [FEATURES];
   int unsigned        feature_fill;
   logic signed [47:0] dot_shadow [HEADS];

   rsp_type     expected_reports[$];
   int unsigned failures;
   int unsigned cycle_count;
   int unsigned sent_items;
   int unsigned got_reports;
   int unsigned update_reports;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic signed [63:0] shr16(input logic signed [63:0] v);
      return v >>> 16;
   endfunction

   function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [47:0] clip48(input logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
      if (v < -64'sh8000_0000_0000) return 48'sh8000_0000_0000;
      return v[47:0];
   endfunction

   // train one head on the buffered vector, return its error
   function automatic logic signed [31:0] train_head(input int unsigned h,
         input logic signed [31:0] target, input logic [16:0] rate);
      logic signed [31:0] err;
      logic signed [31:0] w;
      logic signed [63:0] f;
      logic signed [63:0] g;
      logic signed [31:0] gs;
      logic signed [63:0] r;
      r = $signed({47'd0, rate});
      err = clip32(64'(dot_shadow[h]) + 64'(bias_shadow[h]) - 64'(target));
      for (int unsigned i = 0; i < FEATURES; i++) begin
         w = weight_shadow[h * FEATURES + i];
         f = (i < feature_fill) ? 64'(feature_shadow[i]) : 64'sd0;
         g = shr16(64'(err) * f) + shr16($signed({47'd0, l2_shadow}) * 64'(w));
         gs = clip32(g);
         weight_shadow[h * FEATURES + i] = clip32(64'(w) - shr16(r * 64'(gs)));
      end
      bias_shadow[h] = clip32(64'(bias_shadow[h]) - shr16(r * 64'(err)));
      return err;
   endfunction

   // apply one transaction to the shadow state, queue any result
   function automatic void predict_item(input req_type t);
      rsp_type res;
      logic signed [31:0] tg [HEADS];
      logic signed [31:0] er [HEADS];
      res = '0;
      tg[0] = t.target_h1; tg[1] = t.target_h5;
      tg[2] = t.target_h10; tg[3] = t.target_h20;
      for (int h = 0; h < HEADS; h++) er[h] = '0;
      case (action_type'(t.action))
         ACT_WRITE: begin
            if (t.weight_slot < NSLOTS) weight_shadow[t.weight_slot] = t.write_value;
            else if (t.weight_slot < NSLOTS + HEADS)
               bias_shadow[t.weight_slot - NSLOTS] = t.write_value;
         end
         ACT_READ: begin
            res.report_kind = KIND_READ;
            if (t.weight_slot < NSLOTS) res.read_value = weight_shadow[t.weight_slot];
            else if (t.weight_slot < NSLOTS + HEADS)
               res.read_value = bias_shadow[t.weight_slot - NSLOTS];
            expected_reports.push_back(res);
         end
         ACT_SAMPLE: begin
            if (feature_fill < FEATURES) begin
               feature_shadow[feature_fill] = t.feature_value;
               for (int h = 0; h < HEADS; h++)
                  dot_shadow[h] = clip48(64'(dot_shadow[h]) + shr16(
                     64'(weight_shadow[h * FEATURES + feature_fill]) * 64'(t.feature_value)));
               feature_fill++;
            end
            if (t.last_feature) begin
               for (int h = 0; h < HEADS; h++)
                  if (t.horizon_mask[h]) er[h] = train_head(h, tg[h], t.step_rate);
               feature_fill = 0;
               for (int h = 0; h < HEADS; h++) dot_shadow[h] = '0;
               res.report_kind = KIND_UPDATE;
               res.error_h1 = er[0]; res.error_h5 = er[1];
               res.error_h10 = er[2]; res.error_h20 = er[3];
               res.applied_mask = t.horizon_mask;
               expected_reports.push_back(res);
            end
         end
         default: ;
      endcase
   endfunction

   // send one transaction, with random lead-in idling; valid drops only while idling
   task automatic send_item(input req_type t);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(t);
      sent_items++;
      @(negedge clock);
   endtask

   function automatic req_type random_fields();
      req_type t;
      logic [255:0] bits;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      t = bits[$bits(req_type)-1:0];
      return t;
   endfunction

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(5))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return $signed($urandom_range(131072)) - 32'sd65536;
         3: return $signed($urandom_range(8192)) - 32'sd4096;
         default: return $urandom;
      endcase
   endfunction

   task automatic write_slot(input int unsigned slot, input logic signed [31:0] v);
      req_type t;
      t = random_fields();
      t.action = ACT_WRITE;
      t.weight_slot = slot[6:0];
      t.write_value = v;
      send_item(t);
   endtask

   task automatic read_slot(input int unsigned slot);
      req_type t;
      t = random_fields();
      t.action = ACT_READ;
      t.weight_slot = slot[6:0];
      send_item(t);
   endtask

   task automatic send_sample(input logic signed [31:0] f, input logic last,
         input logic [3:0] mask, input logic [16:0] rate);
      req_type t;
      t = random_fields();
      t.action = ACT_SAMPLE;
      t.feature_value = f;
      t.last_feature = last;
      t.horizon_mask = mask;
      t.step_rate = rate;
      send_item(t);
   endtask

   // drop valid, hold until every expected result is in, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_l2(input logic [16:0] v);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      l2_shadow = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_access_edges();
      write_slot(0, 32'sh7FFF_FFFF);
      write_slot(NSLOTS - 1, 32'sh8000_0000);
      write_slot(NSLOTS + 3, 32'sh0001_0000);
      write_slot(127, 32'sh1234_5678);
      read_slot(0);
      read_slot(NSLOTS - 1);
      read_slot(NSLOTS + 3);
      read_slot(NSLOTS + 4);
      read_slot(127);
      begin
         req_type t;
         t = random_fields();
         t.action = ACT_NONE;
         send_item(t);
      end
   endtask

   task automatic test_vector_cases();
      // full vector, all heads, rate 1.0
      for (int i = 0; i < FEATURES; i++)
         send_sample(random_value(), i == FEATURES - 1, 4'hF, 17'd65536);
      // single-feature short vector, no heads
      send_sample(32'sh7FFF_FFFF, 1'b1, 4'h0, 17'h1FFFF);
      // overlong vector with a mid-vector weight write
      for (int i = 0; i < FEATURES + 3; i++) begin
         if (i == 2) write_slot(FEATURES + 2, 32'sh8000_0000);
         send_sample(32'sh8000_0000, i == FEATURES + 2, 4'h5, 17'd0);
      end
      read_slot(FEATURES + 2);
      read_slot(NSLOTS);
   endtask

   // random writes, reads, no-op items and mostly well-formed vectors with random content
   task automatic test_random_traffic(input int unsigned count);
      int unsigned n;
      int unsigned len;
      n = 0;
      while (n < count) begin
         case ($urandom_range(9))
            0: begin
               write_slot($urandom_range(NSLOTS + HEADS + 2), random_value());
               n++;
            end
            1: begin
               read_slot($urandom_range(127));
               n++;
            end
            2: begin
               req_type t;
               t = random_fields();
               t.action = ACT_NONE;
               send_item(t);
            end
            default: begin
               len = ($urandom_range(7) == 0) ? $urandom_range(FEATURES + 4, 1)
                                              : $urandom_range(6, 1);
               for (int i = 0; i < len; i++) begin
                  send_sample(random_value(), i == len - 1, 4'($urandom),
                     ($urandom_range(3) == 0) ? 17'($urandom) : 17'($urandom_range(4096)));
                  n++;
               end
            end
         endcase
      end
   endtask

   // check each result against the oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               failures++;
            end else begin
               rsp_type e;
               e = expected_reports.pop_front();
               got_reports++;
               if (e.report_kind == KIND_UPDATE) update_reports++;
               if (rsp_data.report_kind !== e.report_kind ||
                   rsp_data.read_value !== e.read_value ||
                   rsp_data.error_h1 !== e.error_h1 || rsp_data.error_h5 !== e.error_h5 ||
                   rsp_data.error_h10 !== e.error_h10 || rsp_data.error_h20 !== e.error_h20 ||
                   rsp_data.applied_mask !== e.applied_mask) begin
                  $display("%0t: mismatch expected %h actual %h", $time, e, rsp_data);
                  failures++;
               end
            end
         end
      end
   end

   // receiver stall
   always @(negedge clock) begin
      rsp_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
   end

   // timeout watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      rsp_stall = 1'b0;
      reset = 1'b1;
      failures = 0;
      cycle_count = 0;
      sent_items = 0;
      got_reports = 0;
      update_reports = 0;
      send_idle_pct = 19;
      recv_idle_pct = 57;
      l2_shadow = '0;
      feature_fill = 0;
      for (int i = 0; i < NSLOTS; i++) weight_shadow[i] = '0;
      for (int h = 0; h < HEADS; h++) begin
         bias_shadow[h] = '0;
         dot_shadow[h] = '0;
      end
      repeat (3) @(negedge clock);
      reset = 1'b0;

      test_access_edges();
      test_vector_cases();
      write_l2(17'd65536);
      test_random_traffic(550);
      // pause until the block has drained
      wait_idle();
      send_idle_pct = 57;
      recv_idle_pct = 19;
      write_l2(17'h1FFFF);
      test_random_traffic(550);
      write_l2(17'd300);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(550);
      write_l2(17'd0);
      test_random_traffic(50);
      wait_idle();

      $display("Covered %0d transactions, %0d results (%0d update reports).",
         sent_items, got_reports, update_reports);
      $display("L2 gain swept over 0, 300, 65536 and the 17-bit maximum.");
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
